[hdl/ule_pkg.sv]
// ule_pkg: shared constants, codes and structs of the utf-8 line editor
// no dependencies; imported by ule_step and utf8_line_editor
package ule_pkg;

	localparam int WidthSlots     = 256;
	localparam int SlotW          = $clog2(WidthSlots);
	localparam int MaxCapacityInt = 4096;
	localparam int CountW         = $clog2(MaxCapacityInt + 1);
	localparam int IndexW         = $clog2(MaxCapacityInt);
	localparam int WidthW         = 8;

	localparam logic [CountW-1:0] MaxCapacity = CountW'(MaxCapacityInt);
	localparam logic [CountW-1:0] CapReset    = CountW'(256);

	localparam logic [7:0] ByteBs   = 8'h08;
	localparam logic [7:0] ByteDel  = 8'h7F;
	localparam logic [7:0] ByteLf   = 8'h0A;
	localparam logic [7:0] ByteCr   = 8'h0D;
	localparam logic [7:0] ContMask = 8'hC0;
	localparam logic [7:0] ContTag  = 8'h80;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_FINISH = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_PROGRESS = 2'd0,
		STAT_ACCEPTED = 2'd1,
		STAT_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		logic              finished;
		status_t           fin_status;
		logic [CountW-1:0] byte_count;
		logic [CountW-1:0] symbol_count;
	} line_state_t;

	typedef struct packed {
		action_t           action;
		logic [IndexW-1:0] write_index;
		logic [WidthW-1:0] removed_count;
		logic [CountW-1:0] stored_length;
		status_t           status;
	} line_result_t;

	typedef struct packed {
		logic              en;
		logic [SlotW-1:0]  addr;
		logic [WidthW-1:0] data;
	} ring_wr_t;

endpackage

[hdl/utf8_line_editor.sv]
// utf8_line_editor: line intake with utf-8 aware erase, top level
// depends on ule_pkg, ule_ring_ram and ule_step
// an item passes the execute stage, where it waits on its ring read, and then
// the result register; a stall on the result channel holds it in the execute stage
// throughput: one item per cycle while the result channel is not stalled
// a write to the ring entry just read is forwarded to the following item
// reset: counters and finished flag cleared, capacity set to 256
// the width ring is not cleared, no clearing pass after reset
module utf8_line_editor (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [11:0] write_index,
	output logic [7:0]  removed_count,
	output logic [12:0] stored_length,
	output logic [1:0]  status
);
	import ule_pkg::*;

	// configuration register
	logic [CountW-1:0] cap_q;
	logic [CountW-1:0] cap_eff;

	// committed line state
	line_state_t st_q;
	line_state_t st_n;

	// execute stage: item waiting on its ring read
	logic              valid_s1;
	logic [1:0]        kind_s1;
	logic [7:0]        byte_s1;
	logic              fwd_hit_s1;
	logic [WidthW-1:0] fwd_data_s1;

	// result register
	logic         out_valid_q;
	line_result_t out_q;

	line_result_t      res;
	ring_wr_t          wr;
	logic [WidthW-1:0] rd_data;
	logic [WidthW-1:0] width;
	logic [CountW-1:0] sym_next;
	logic [SlotW-1:0]  rd_addr;
	logic              fire_s1;
	logic              in_acc;

	assign cfg_ready = 1'b1;
	assign cap_eff   = (cap_q > MaxCapacity) ? MaxCapacity : cap_q;

	// the execute stage moves on when the result register is free or drains
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign in_acc   = in_valid && in_ready;

	// read address of the new item comes from the symbol count it will see
	assign sym_next = fire_s1 ? st_n.symbol_count : st_q.symbol_count;
	assign rd_addr  = sym_next[SlotW-1:0] - 1'b1;

	// take the width just written by the previous item if it hit the same slot
	assign width = fwd_hit_s1 ? fwd_data_s1 : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	ule_ring_ram #(
		.Depth(WidthSlots),
		.Width(WidthW)
	) u_ring (
		.clk     (clk),
		.wr_en   (fire_s1 && wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_en   (in_acc),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ule_step u_step (
		.st        (st_q),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.width     (width),
		.cap_eff   (cap_eff),
		.st_n      (st_n),
		.res       (res),
		.wr        (wr)
	);

	// line state commits as the item leaves the execute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.finished     <= 1'b0;
			st_q.fin_status   <= STAT_PROGRESS;
			st_q.byte_count   <= '0;
			st_q.symbol_count <= '0;
		end else if (fire_s1) begin
			st_q <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the execute stage and the forwarding capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1     <= kind;
			byte_s1     <= data_byte;
			fwd_hit_s1  <= fire_s1 && wr.en && (wr.addr == rd_addr);
			fwd_data_s1 <= wr.data;
		end
	end

	// result register parts the execute stage from the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = out_q.action;
	assign write_index   = out_q.write_index;
	assign removed_count = out_q.removed_count;
	assign stored_length = out_q.stored_length;
	assign status        = out_q.status;

	// stored length never passes the largest store
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stored_length <= MaxCapacity)
		else $error("stored length beyond maximum capacity");

	// an append lands at the end of the line and carries no removal
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_APPEND |->
			CountW'(write_index) + 1'b1 == stored_length && removed_count == '0)
		else $error("append fields inconsistent");

	// a finished line always has a final status
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.finished |-> st_q.fin_status == STAT_ACCEPTED
			|| st_q.fin_status == STAT_TOO_LONG)
		else $error("finished line without final status");

	// a stalled execute stage keeps its item and the line state
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1 && $stable(kind_s1) && $stable(st_q))
		else $error("execute stage lost its item while stalled");

endmodule

[hdl/ule_ring_ram.sv]
// ule_ring_ram: generic one-write one-read synchronous ram, registered read
// no dependencies; holds the ring of character widths
module ule_ring_ram #(
	parameter int Depth = 256,
	parameter int Width = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/ule_step.sv]
// ule_step: per-item decision logic, next line state, result and ring write
// depends on ule_pkg
module ule_step (
	input  ule_pkg::line_state_t         st,
	input  logic [1:0]                   kind,
	input  logic [7:0]                   data_byte,
	input  logic [ule_pkg::WidthW-1:0]   width,
	input  logic [ule_pkg::CountW-1:0]   cap_eff,
	output ule_pkg::line_state_t         st_n,
	output ule_pkg::line_result_t        res,
	output ule_pkg::ring_wr_t            wr
);
	import ule_pkg::*;

	status_t           cur_status;
	logic [SlotW-1:0]  prev_slot;
	logic [WidthW-1:0] w_nz;
	logic [CountW-1:0] w_clip;

	always_comb begin
		cur_status = st.finished ? st.fin_status : STAT_PROGRESS;
		prev_slot  = st.symbol_count[SlotW-1:0] - 1'b1;
		w_nz       = (width == '0) ? WidthW'(1) : width;
		w_clip     = (CountW'(w_nz) > st.byte_count) ? st.byte_count : CountW'(w_nz);

		st_n = st;
		res.action        = ACT_NONE;
		res.write_index   = '0;
		res.removed_count = '0;
		res.stored_length = st.byte_count;
		res.status        = cur_status;
		wr.en   = 1'b0;
		wr.addr = prev_slot;
		wr.data = width + 1'b1;

		case (kind)
			KIND_START: begin
				st_n.finished     = 1'b0;
				st_n.fin_status   = STAT_PROGRESS;
				st_n.byte_count   = '0;
				st_n.symbol_count = '0;
				res.stored_length = '0;
				res.status        = STAT_PROGRESS;
			end
			KIND_END: begin
				if (!st.finished) begin
					st_n.finished   = 1'b1;
					st_n.fin_status = STAT_ACCEPTED;
					res.action      = ACT_FINISH;
					res.status      = STAT_ACCEPTED;
				end
			end
			KIND_DATA: begin
				if (st.finished) begin
					// line already over, nothing changes
				end else if (data_byte == ByteLf || data_byte == ByteCr) begin
					st_n.finished   = 1'b1;
					st_n.fin_status = STAT_ACCEPTED;
					res.action      = ACT_FINISH;
					res.status      = STAT_ACCEPTED;
				end else if (data_byte == ByteBs || data_byte == ByteDel) begin
					if (st.symbol_count != '0) begin
						st_n.symbol_count = st.symbol_count - 1'b1;
						st_n.byte_count   = st.byte_count - w_clip;
						res.stored_length = st.byte_count - w_clip;
						if (w_clip != '0) begin
							res.action        = ACT_REMOVE;
							res.removed_count = w_clip[WidthW-1:0];
						end
					end
				end else if (st.byte_count >= cap_eff) begin
					st_n.finished   = 1'b1;
					st_n.fin_status = STAT_TOO_LONG;
					res.action      = ACT_FINISH;
					res.status      = STAT_TOO_LONG;
				end else begin
					st_n.byte_count   = st.byte_count + 1'b1;
					res.action        = ACT_APPEND;
					res.write_index   = st.byte_count[IndexW-1:0];
					res.stored_length = st.byte_count + 1'b1;
					if ((data_byte & ContMask) == ContTag) begin
						// continuation widens the last character, if any
						wr.en = (st.symbol_count != '0);
					end else begin
						wr.en             = 1'b1;
						wr.addr           = st.symbol_count[SlotW-1:0];
						wr.data           = WidthW'(1);
						st_n.symbol_count = st.symbol_count + 1'b1;
					end
				end
			end
			default: begin
				// unknown kind is ignored
			end
		endcase
	end

endmodule
